### src/qxmm_pkg.sv
// shared widths, reset values, register indexes and arithmetic helpers for the motor mixer
package qxmm_pkg;

  localparam int THR_W   = 12;
  localparam int TERM_W  = 16;
  localparam int SLEW_W  = 15;
  localparam int PULSE_W = 12;
  localparam int TRIM_W  = 8;
  localparam int MOTOR_W = 16;
  localparam int MIX_W   = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;

  localparam logic [SLEW_W-1:0]  SLEW_RESET  = 15'd30;
  localparam logic [THR_W-1:0]   ARM_RESET   = 12'd1020;
  localparam logic [PULSE_W-1:0] IDLE_RESET  = 12'd1000;
  localparam logic [TRIM_W-1:0]  TRIM_RESET  = 8'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SLEW_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_PULSE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ONE_TRIM = 2'd3;

  // move last toward raw by at most lim
  function automatic logic signed [TERM_W-1:0] slew_step(
    input logic signed [TERM_W-1:0] last,
    input logic signed [TERM_W-1:0] raw,
    input logic [SLEW_W-1:0]        lim
  );
    logic signed [TERM_W:0] d;
    logic signed [TERM_W:0] lim_s;
    logic signed [TERM_W:0] sum;
    lim_s = signed'({2'b00, lim});
    d = (TERM_W+1)'(raw) - (TERM_W+1)'(last);
    if (d > lim_s) begin
      d = lim_s;
    end else if (d < -lim_s) begin
      d = -lim_s;
    end
    sum = (TERM_W+1)'(last) + d;
    return sum[TERM_W-1:0];
  endfunction

  function automatic logic [MOTOR_W-1:0] sat16(input logic signed [MIX_W-1:0] v);
    logic [MOTOR_W-1:0] res;
    if (v > 20'sd32767) begin
      res = 16'h7fff;
    end else if (v < -20'sd32768) begin
      res = 16'h8000;
    end else begin
      res = v[MOTOR_W-1:0];
    end
    return res;
  endfunction

endpackage

### src/quad_x_motor_mixer_slew_top.sv
// x-frame motor mixer with slew-limited roll, pitch and yaw terms
// One word is taken per clock while the output is not stalled; it passes through
// one input register, then a single pass of slew limiting, mixing and
// saturation into the result register. The rate of one word per cycle is
// set by the stored roll, pitch and yaw terms, which feed back to the next word
// through the slew logic. While the result register holds a word that is
// not taken, the input register still fills, so up to two words sit inside.
// Pulses saturate to signed 16 bits; at or below the arm threshold all four motors
// give the idle pulse and tuser (armed) is low. Configuration writes take
// effect at once and are meant for idle periods only.
module quad_x_motor_mixer_slew_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [qxmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qxmm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // throttle_in, roll_term, pitch_term, yaw_term, zero fill
  input  logic [qxmm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // motor_front_a, motor_front_b, motor_rear_a, motor_rear_b
  output logic [qxmm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // armed
  output logic                             m_axis_tuser
);

  logic [qxmm_pkg::SLEW_W-1:0]  slew_limit;
  logic [qxmm_pkg::THR_W-1:0]   arm_threshold;
  logic [qxmm_pkg::PULSE_W-1:0] idle_pulse;
  logic [qxmm_pkg::TRIM_W-1:0]  motor_one_trim;

  logic                                in_valid;
  logic [qxmm_pkg::THR_W-1:0]          in_thr;
  logic signed [qxmm_pkg::TERM_W-1:0]  in_roll;
  logic signed [qxmm_pkg::TERM_W-1:0]  in_pitch;
  logic signed [qxmm_pkg::TERM_W-1:0]  in_yaw;

  logic signed [qxmm_pkg::TERM_W-1:0]  prev_roll;
  logic signed [qxmm_pkg::TERM_W-1:0]  prev_pitch;
  logic signed [qxmm_pkg::TERM_W-1:0]  prev_yaw;

  logic                                out_valid;
  logic [qxmm_pkg::OUT_DATA_W-1:0]     out_data;
  logic                                out_armed;

  logic                                advance;
  logic signed [qxmm_pkg::TERM_W-1:0]  roll_next;
  logic signed [qxmm_pkg::TERM_W-1:0]  pitch_next;
  logic signed [qxmm_pkg::TERM_W-1:0]  yaw_next;
  logic signed [qxmm_pkg::MIX_W-1:0]   t_ext;
  logic signed [qxmm_pkg::MIX_W-1:0]   r_ext;
  logic signed [qxmm_pkg::MIX_W-1:0]   p_ext;
  logic signed [qxmm_pkg::MIX_W-1:0]   y_ext;
  logic signed [qxmm_pkg::MIX_W-1:0]   trim_ext;
  logic                                armed_next;
  logic [qxmm_pkg::OUT_DATA_W-1:0]     out_data_next;
  logic [qxmm_pkg::MOTOR_W-1:0]        idle_ext;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_armed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slew_limit     <= qxmm_pkg::SLEW_RESET;
      arm_threshold  <= qxmm_pkg::ARM_RESET;
      idle_pulse     <= qxmm_pkg::IDLE_RESET;
      motor_one_trim <= qxmm_pkg::TRIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qxmm_pkg::REG_SLEW_LIMIT:     slew_limit     <= cfg_data;
        qxmm_pkg::REG_ARM_THRESHOLD:  arm_threshold  <= cfg_data[qxmm_pkg::THR_W-1:0];
        qxmm_pkg::REG_IDLE_PULSE:     idle_pulse     <= cfg_data[qxmm_pkg::PULSE_W-1:0];
        qxmm_pkg::REG_MOTOR_ONE_TRIM: motor_one_trim <= cfg_data[qxmm_pkg::TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_thr   <= s_axis_tdata[11:0];
      in_roll  <= s_axis_tdata[27:12];
      in_pitch <= s_axis_tdata[43:28];
      in_yaw   <= s_axis_tdata[59:44];
    end
  end

  // slew limiting and mixing
  always_comb begin
    roll_next  = qxmm_pkg::slew_step(prev_roll,  in_roll,  slew_limit);
    pitch_next = qxmm_pkg::slew_step(prev_pitch, in_pitch, slew_limit);
    yaw_next   = qxmm_pkg::slew_step(prev_yaw,   in_yaw,   slew_limit);
    t_ext    = signed'({8'd0, in_thr});
    trim_ext = signed'({12'd0, motor_one_trim});
    r_ext    = qxmm_pkg::MIX_W'(roll_next);
    p_ext    = qxmm_pkg::MIX_W'(pitch_next);
    y_ext    = qxmm_pkg::MIX_W'(yaw_next);
    idle_ext = {4'd0, idle_pulse};
    armed_next = in_thr > arm_threshold;
    if (armed_next) begin
      out_data_next = {
        qxmm_pkg::sat16(t_ext - r_ext + p_ext + y_ext),
        qxmm_pkg::sat16(t_ext - r_ext - p_ext - y_ext),
        qxmm_pkg::sat16(t_ext + r_ext - p_ext + y_ext - trim_ext),
        qxmm_pkg::sat16(t_ext + r_ext + p_ext - y_ext)
      };
    end else begin
      out_data_next = {idle_ext, idle_ext, idle_ext, idle_ext};
    end
  end

  // stored terms
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_roll  <= '0;
      prev_pitch <= '0;
      prev_yaw   <= '0;
    end else if (advance) begin
      prev_roll  <= roll_next;
      prev_pitch <= pitch_next;
      prev_yaw   <= yaw_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data  <= out_data_next;
      out_armed <= armed_next;
    end
  end

endmodule

### sim/quad_x_motor_mixer_slew_top_test.sv
// self-checking testbench for the x-frame motor mixer: directed table, then randomised words
`timescale 1ns / 1ps

module quad_x_motor_mixer_slew_top_test;
  import qxmm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int WORDS_PER_PHASE = 85;

  typedef struct packed {
    logic                          armed;
    logic [3:0][MOTOR_W-1:0]       motor;
  } mix_result_t;

  typedef struct packed {
    int                            cfg_set;
    logic [THR_W-1:0]              thr;
    logic signed [TERM_W-1:0]      roll;
    logic signed [TERM_W-1:0]      pitch;
    logic signed [TERM_W-1:0]      yaw;
    bit                            typed;
    mix_result_t                   want;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    m_axis_tuser;

  // mirror of the block's registers and held terms
  int slew_cap;
  int arm_level;
  int idle_level;
  int trim_amt;
  int held_roll;
  int held_pitch;
  int held_yaw;

  mix_result_t pending_mixes [$];
  stim_row_t   dir_rows [$];
  int          fail_count;
  int unsigned cycle_count;
  bit          hold_request;

  string field_names [5] = '{"motor_front_a", "motor_front_b", "motor_rear_a",
                             "motor_rear_b", "armed"};

  quad_x_motor_mixer_slew_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  function automatic int stall_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic int slew_toward(input int last, input int raw);
    int d;
    d = raw - last;
    if (d > slew_cap) d = slew_cap;
    if (d < -slew_cap) d = -slew_cap;
    return last + d;
  endfunction

  function automatic logic [MOTOR_W-1:0] clamp_pulse(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[MOTOR_W-1:0];
  endfunction

  function automatic mix_result_t mix_predict(input logic [THR_W-1:0] thr,
                                              input logic signed [TERM_W-1:0] raw_r,
                                              input logic signed [TERM_W-1:0] raw_p,
                                              input logic signed [TERM_W-1:0] raw_y);
    mix_result_t res;
    int t;
    held_roll  = slew_toward(held_roll, int'(raw_r));
    held_pitch = slew_toward(held_pitch, int'(raw_p));
    held_yaw   = slew_toward(held_yaw, int'(raw_y));
    t = int'(thr);
    if (t > arm_level) begin
      res.motor[0] = clamp_pulse(t + held_roll + held_pitch - held_yaw);
      res.motor[1] = clamp_pulse(t + held_roll - held_pitch + held_yaw - trim_amt);
      res.motor[2] = clamp_pulse(t - held_roll - held_pitch - held_yaw);
      res.motor[3] = clamp_pulse(t - held_roll + held_pitch + held_yaw);
      res.armed = 1'b1;
    end else begin
      for (int k = 0; k < 4; k++) res.motor[k] = MOTOR_W'(idle_level);
      res.armed = 1'b0;
    end
    return res;
  endfunction

  // random term: full range, near the held value, extremes or small
  function automatic logic signed [TERM_W-1:0] pick_term(input int held);
    int v;
    int span;
    span = 2 * slew_cap + 4;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($signed(16'($urandom)));
      4, 5, 6:    v = held + $urandom_range(0, 2 * span) - span;
      7:          v = 32767;
      8:          v = -32768;
      default:    v = $urandom_range(0, 1000) - 500;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[TERM_W-1:0];
  endfunction

  function automatic int pick_cfg(input int maxv);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return maxv;
      2, 3:    return $urandom_range(1, 64);
      default: return $urandom_range(0, maxv);
    endcase
  endfunction

  task automatic add_row(input int set, input int thr, input int r, input int p,
                         input int y, input bit typed, input int m0, input int m1,
                         input int m2, input int m3, input bit armed);
    stim_row_t row;
    row.cfg_set = set;
    row.thr = thr[THR_W-1:0];
    row.roll = r[TERM_W-1:0];
    row.pitch = p[TERM_W-1:0];
    row.yaw = y[TERM_W-1:0];
    row.typed = typed;
    row.want.motor[0] = m0[MOTOR_W-1:0];
    row.want.motor[1] = m1[MOTOR_W-1:0];
    row.want.motor[2] = m2[MOTOR_W-1:0];
    row.want.motor[3] = m3[MOTOR_W-1:0];
    row.want.armed = armed;
    dir_rows.push_back(row);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      REG_SLEW_LIMIT:     slew_cap = val;
      REG_ARM_THRESHOLD:  arm_level = val;
      REG_IDLE_PULSE:     idle_level = val;
      REG_MOTOR_ONE_TRIM: trim_amt = val;
      default: ;
    endcase
  endtask

  // wait for the block to empty, then rewrite all four registers
  task automatic apply_config(input int slew, input int arm, input int idle, input int trim);
    s_axis_tvalid <= 1'b0;
    while (pending_mixes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_SLEW_LIMIT, slew);
    write_reg(REG_ARM_THRESHOLD, arm);
    write_reg(REG_IDLE_PULSE, idle);
    write_reg(REG_MOTOR_ONE_TRIM, trim);
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input logic [THR_W-1:0] thr,
                           input logic signed [TERM_W-1:0] r,
                           input logic signed [TERM_W-1:0] p,
                           input logic signed [TERM_W-1:0] y,
                           input bit typed, input mix_result_t want, input bit gappy);
    mix_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, y, p, r, thr};
    do @(posedge clk); while (!s_axis_tready);
    predicted = mix_predict(thr, r, p, y);
    pending_mixes.push_back(typed ? want : predicted);
    if (gappy && $urandom_range(0, 1) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat (stall_len()) @(posedge clk);
    end
  endtask

  // result sink with bursts, stalls and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(20, 150)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    mix_result_t got;
    mix_result_t exp_mix;
    logic [15:0] exp_v;
    logic [15:0] got_v;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.motor = m_axis_tdata;
      got.armed = m_axis_tuser;
      if (pending_mixes.size() == 0) begin
        $display("%0t: unexpected word, actual %h armed %b", $time, m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        exp_mix = pending_mixes.pop_front();
        for (int k = 0; k < 5; k++) begin
          exp_v = (k < 4) ? exp_mix.motor[k] : 16'(exp_mix.armed);
          got_v = (k < 4) ? got.motor[k] : 16'(got.armed);
          if (exp_v !== got_v) begin
            $display("%0t: %s expected %h actual %h", $time, field_names[k], exp_v, got_v);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quad_x_motor_mixer_slew_top_test failed");
      $finish;
    end
  end

  initial begin
    int cur_set;
    bit gappy;
    int thr_v;
    int dir_cfg [4][4];
    mix_result_t none;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    fail_count = 0;
    cycle_count = 0;
    hold_request = 1'b0;
    none = '0;
    slew_cap = int'(SLEW_RESET);
    arm_level = int'(ARM_RESET);
    idle_level = int'(IDLE_RESET);
    trim_amt = int'(TRIM_RESET);
    held_roll = 0;
    held_pitch = 0;
    held_yaw = 0;
    dir_cfg = '{'{30, 1020, 1000, 5}, '{32767, 0, 4095, 255},
                '{0, 4095, 0, 0}, '{0, 0, 2047, 128}};

    // reset values, threshold edge and full-scale inputs
    add_row(0, 4095, 0, 0, 0, 1, 4095, 4090, 4095, 4095, 1);
    add_row(0, 0, 32767, -32768, 32767, 1, 1000, 1000, 1000, 1000, 0);
    add_row(0, 1020, -32768, 32767, -32768, 1, 1000, 1000, 1000, 1000, 0);
    add_row(0, 1021, 100, -100, 5, 0, 0, 0, 0, 0, 0);
    add_row(0, 2048, 20, 20, 20, 0, 0, 0, 0, 0, 0);
    add_row(0, 4095, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0);
    // open slew, largest trim: mix saturates both ways
    add_row(1, 0, 1, 2, 3, 1, 4095, 4095, 4095, 4095, 0);
    add_row(1, 4095, 32767, 32767, -32768, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, -32768, -32768, 32767, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, -32768, -32768, 32767, 0, 0, 0, 0, 0, 0);
    add_row(1, 4095, 32767, -32768, 32767, 0, 0, 0, 0, 0, 0);
    add_row(1, 2048, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // threshold at top: never armed, zero idle pulse
    add_row(2, 4095, 32767, 32767, 32767, 1, 0, 0, 0, 0, 0);
    add_row(2, 0, -32768, -32768, -32768, 1, 0, 0, 0, 0, 0);
    // zero slew holds the stored terms
    add_row(3, 4095, 32767, -32768, 0, 0, 0, 0, 0, 0, 0);
    add_row(3, 1, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_set = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_set != cur_set) begin
        cur_set = dir_rows[i].cfg_set;
        apply_config(dir_cfg[cur_set][0], dir_cfg[cur_set][1],
                     dir_cfg[cur_set][2], dir_cfg[cur_set][3]);
      end
      send_word(dir_rows[i].thr, dir_rows[i].roll, dir_rows[i].pitch, dir_rows[i].yaw,
                dir_rows[i].typed, dir_rows[i].want, 1'b1);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_config(pick_cfg(32767), pick_cfg(4095), pick_cfg(4095), pick_cfg(255));
      gappy = (ph != 3) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (ph == 3 && n == 40) hold_request = 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: thr_v = arm_level + $urandom_range(0, 100) - 50;
          5, 6, 7:       thr_v = $urandom_range(0, 4095);
          8:             thr_v = 4095;
          default:       thr_v = 0;
        endcase
        if (thr_v < 0) thr_v = 0;
        if (thr_v > 4095) thr_v = 4095;
        send_word(thr_v[THR_W-1:0], pick_term(held_roll), pick_term(held_pitch),
                  pick_term(held_yaw), 1'b0, none, gappy);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_mixes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("quad_x_motor_mixer_slew_top_test passed");
    end else begin
      $display("quad_x_motor_mixer_slew_top_test failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/qxmm_pkg.sv
src/quad_x_motor_mixer_slew_top.sv
sim/quad_x_motor_mixer_slew_top_test.sv
